// ===== rtl/core/idp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idp_pkg
// Shared types and constants for the initial DCID patcher.
// ----------------------------------------------------------------------------
package idp_pkg;

    localparam int MAX_ID_LEN = 20;
    localparam int MIN_PKT_LEN = 6;   // fixed long-header bytes ahead of the ID
    localparam int IDLEN_POS = 5;     // byte that carries the DCID length

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_ARGS  = 3'd1,
        ST_SHORT_HDR = 3'd2,
        ST_BAD_IDLEN = 3'd3,
        ST_MISMATCH  = 3'd4,
        ST_TOO_SHORT = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        REG_ID_LEN  = 2'd0,
        REG_ID_LOW  = 2'd1,
        REG_ID_MID  = 2'd2,
        REG_ID_HIGH = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [4:0]  id_len;
        logic [63:0] id_low;
        logic [63:0] id_mid;
        logic [31:0] id_high;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        t_status    status;
    } t_result;

endpackage

// ===== rtl/core/idp_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idp_cfg
// APB register file holding the replacement connection ID.
// ----------------------------------------------------------------------------
module idp_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [63:0]    pwdata,
    output logic [63:0]    prdata,
    output logic           pready,
    output idp_pkg::t_cfg  o_cfg
);
    import idp_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:3]);
    assign w_wr   = psel & penable & pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_ID_LEN:  n_cfg.id_len  = pwdata[4:0];
                REG_ID_LOW:  n_cfg.id_low  = pwdata;
                REG_ID_MID:  n_cfg.id_mid  = pwdata;
                REG_ID_HIGH: n_cfg.id_high = pwdata[31:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            REG_ID_LEN:  prdata = {59'd0, r_cfg.id_len};
            REG_ID_LOW:  prdata = r_cfg.id_low;
            REG_ID_MID:  prdata = r_cfg.id_mid;
            REG_ID_HIGH: prdata = {32'd0, r_cfg.id_high};
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/idp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idp_ctrl
// Per-packet position tracking, header checks and DCID byte substitution.
// ----------------------------------------------------------------------------
module idp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_packet_byte,
    input  logic [15:0]       i_packet_length,
    input  logic              i_last_byte,
    input  idp_pkg::t_cfg     i_cfg,
    output idp_pkg::t_result  o_result
);
    import idp_pkg::*;

    logic [15:0] r_pos;
    logic [15:0] n_pos;
    t_status     r_err;
    t_status     n_err;
    logic        r_patch;
    logic        n_patch;
    logic [4:0]  r_idlen;
    logic [4:0]  n_idlen;

    logic [159:0] w_id;
    logic [15:0]  w_off;
    logic [7:0]   w_byte;
    t_status      w_st;

    assign w_id  = {i_cfg.id_high, i_cfg.id_mid, i_cfg.id_low};
    assign w_off = r_pos - 16'(MIN_PKT_LEN);

    always_comb begin
        n_err   = r_err;
        n_patch = r_patch;
        n_idlen = r_idlen;
        w_byte  = i_packet_byte;

        if (r_pos == 16'd0) begin
            if (i_packet_length < 16'(MIN_PKT_LEN) || i_cfg.id_len == 5'd0
                    || i_cfg.id_len > 5'(MAX_ID_LEN)) begin
                n_err = ST_BAD_ARGS;
            end else if (!i_packet_byte[7]) begin
                n_err = ST_SHORT_HDR;
            end
        end else if (r_pos == 16'(IDLEN_POS) && r_err == ST_OK) begin
            if (i_packet_byte == 8'd0 || i_packet_byte > 8'(MAX_ID_LEN)) begin
                n_err = ST_BAD_IDLEN;
            end else if ({3'd0, i_cfg.id_len} != i_packet_byte) begin
                n_err = ST_MISMATCH;
            end else if ({1'b0, i_packet_length}
                    < 17'(MIN_PKT_LEN) + {9'd0, i_packet_byte}) begin
                n_err = ST_TOO_SHORT;
            end else begin
                n_patch = 1'b1;
                n_idlen = i_packet_byte[4:0];
            end
        end else if (r_pos >= 16'(MIN_PKT_LEN) && r_patch
                && w_off < {11'd0, r_idlen}) begin
            // offset is below the ID length, so it fits in five bits
            w_byte = w_id[{w_off[4:0], 3'b000} +: 8];
        end

        w_st = ST_OK;
        n_pos = r_pos;
        if (i_last_byte) begin
            w_st = n_err;
            // stream ended before the ID length byte
            if (w_st == ST_OK && r_pos < 16'(IDLEN_POS)) begin
                w_st = ST_TOO_SHORT;
            end
            n_pos   = '0;
            n_err   = ST_OK;
            n_patch = 1'b0;
            n_idlen = '0;
        end else if (r_pos != 16'hFFFF) begin
            n_pos = r_pos + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_err   <= ST_OK;
            r_patch <= 1'b0;
            r_idlen <= '0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_err   <= n_err;
            r_patch <= n_patch;
            r_idlen <= n_idlen;
        end
    end

    assign o_result.out_byte = w_byte;
    assign o_result.out_last = i_last_byte;
    assign o_result.status   = w_st;

endmodule

// ===== rtl/core/idp_outbuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idp_outbuf
// Result register with a skid entry so input is taken while output waits.
// ----------------------------------------------------------------------------
module idp_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  idp_pkg::t_result  i_result,
    input  logic              i_out_stall,
    output logic              o_full,
    output logic              o_out_valid,
    output idp_pkg::t_result  o_result
);
    import idp_pkg::*;

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result n_out;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_skid;
    t_result n_skid;
    logic    w_take;

    assign w_take = r_out_valid & ~i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (i_accept) begin
            if (!r_out_valid || w_take) begin
                n_out_valid = 1'b1;
                n_out       = i_result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_result;
            end
        end else if (w_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_accept)
        else $error("request accepted while skid entry is occupied");

    a_blocked_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_out_valid && i_out_stall) |=> (r_skid_valid && r_skid == $past(i_result)))
        else $error("blocked request not captured in skid entry");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> (r_out == $past(r_skid) && !r_skid_valid))
        else $error("skid entry not moved to output register");
`endif

endmodule

// ===== rtl/core/initial_dcid_patcher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// initial_dcid_patcher_core
// Streaming rewrite of the Destination Connection ID of a QUIC long header.
//
// Input channel: one packet byte per request with the packet length and a
// last flag (i_in_valid / o_in_stall). Output channel: the byte, passed or
// replaced by the configured ID, its last flag and a status code that is
// nonzero only on the last byte (o_out_valid / i_out_stall).
// Throughput is one byte per cycle while no stall holds the flow; each result
// is registered after its request is accepted, in a result register. A skid
// entry behind it takes one more request while the receiver stalls; o_in_stall
// rises only once that entry is occupied. Checks and substitution are one pass
// of logic on the position counter and per-packet flags.
// Configuration: APB, 64-bit data, registers at 0x00 (ID length), 0x08, 0x10,
// 0x18 (ID bytes). Write only while no packet is in flight.
// Reset (synchronous, active low) clears registers, packet state and both
// output entries; the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module initial_dcid_patcher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_packet_byte,
    input  logic [15:0] i_packet_length,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [2:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import idp_pkg::*;

    t_cfg    w_cfg;
    t_result w_res;
    t_result w_out;
    logic    w_full;
    logic    w_accept;

    assign w_accept   = i_in_valid & ~w_full;
    assign o_in_stall = w_full;

    idp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    idp_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_packet_byte   (i_packet_byte),
        .i_packet_length (i_packet_length),
        .i_last_byte     (i_last_byte),
        .i_cfg           (w_cfg),
        .o_result        (w_res)
    );

    idp_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_result    (w_res),
        .i_out_stall (i_out_stall),
        .o_full      (w_full),
        .o_out_valid (o_out_valid),
        .o_result    (w_out)
    );

    assign o_out_byte = w_out.out_byte;
    assign o_out_last = w_out.out_last;
    assign o_status   = w_out.status;

endmodule

// ===== test/initial_dcid_patcher_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// initial_dcid_patcher_core_tb
// Self-checking bench for the DCID patcher. Packets go in byte by byte, and
// each output byte is compared with a local model of the header checks and
// the ID rewrite. Directed packets cover every status code. Random traffic
// follows under several ID register settings. The last packets run back to
// back with no idling on either side.
// ----------------------------------------------------------------------------
module initial_dcid_patcher_core_tb;
    import idp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_packet_byte = '0;
    logic [15:0] i_packet_length = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic [2:0]  o_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    initial_dcid_patcher_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_packet_byte  (i_packet_byte),
        .i_packet_length(i_packet_length),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_out_last     (o_out_last),
        .o_status       (o_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // register copies
    logic [4:0]  cfg_len = '0;
    logic [63:0] cfg_lo = '0;
    logic [63:0] cfg_mid = '0;
    logic [31:0] cfg_hi = '0;

    // per-packet tracking
    logic [15:0] pkt_pos = '0;
    t_status     pkt_err = ST_OK;
    logic        patch_on = 1'b0;
    logic [4:0]  seen_len = '0;

    t_result     expected_bytes[$];
    logic [7:0]  tx_bytes[$];

    bit          quiet = 1'b0;
    int          fail_count = 0;
    int          bytes_checked = 0;
    int          packets_sent = 0;
    int          bytes_rewritten = 0;
    int          status_seen[8];
    int          stall_left = 0;
    int          idle_cycles = 0;

    task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
        if (fail_count < 20)
            $display("mismatch %s at result %0d: expected %0h, got %0h",
                     field, bytes_checked, want, got);
        fail_count++;
    endtask

    function automatic logic [7:0] id_byte(int k);
        logic [159:0] ids;
        ids = {cfg_hi, cfg_mid, cfg_lo};
        return ids[k*8 +: 8];
    endfunction

    // header checks run on bytes 0 and 5; the ID field is rewritten after that
    function automatic t_result patch_byte(logic [7:0] b, logic [15:0] plen, logic last);
        t_result r;
        r.out_byte = b;
        r.out_last = last;
        r.status   = ST_OK;
        if (pkt_pos == 0) begin
            if (plen < MIN_PKT_LEN || cfg_len == 0 || cfg_len > MAX_ID_LEN)
                pkt_err = ST_BAD_ARGS;
            else if (!b[7])
                pkt_err = ST_SHORT_HDR;
        end else if (pkt_pos == IDLEN_POS && pkt_err == ST_OK) begin
            if (b == 0 || b > MAX_ID_LEN)
                pkt_err = ST_BAD_IDLEN;
            else if (cfg_len != b)
                pkt_err = ST_MISMATCH;
            else if (plen < MIN_PKT_LEN + b)
                pkt_err = ST_TOO_SHORT;
            else begin
                patch_on = 1'b1;
                seen_len = b[4:0];
            end
        end else if (pkt_pos >= MIN_PKT_LEN && patch_on && pkt_pos - MIN_PKT_LEN < seen_len) begin
            r.out_byte = id_byte(pkt_pos - MIN_PKT_LEN);
            bytes_rewritten++;
        end
        if (last) begin
            r.status = pkt_err;
            if (pkt_err == ST_OK && pkt_pos < IDLEN_POS)
                r.status = ST_TOO_SHORT;
            pkt_pos  = '0;
            pkt_err  = ST_OK;
            patch_on = 1'b0;
            seen_len = '0;
        end else if (pkt_pos != 16'hFFFF) begin
            pkt_pos = pkt_pos + 16'd1;
        end
        return r;
    endfunction

    // valid is left high after acceptance; a pause in the next call or wait_for_results lowers it
    task automatic send_byte(logic [7:0] b, logic [15:0] plen, logic last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_packet_byte   <= b;
        i_packet_length <= plen;
        i_last_byte     <= last;
        do @(posedge i_clk); while (o_in_stall);
        expected_bytes.push_back(patch_byte(b, plen, last));
    endtask

    task automatic send_packet(logic [15:0] plen);
        for (int i = 0; i < tx_bytes.size(); i++)
            send_byte(tx_bytes[i], plen, i == tx_bytes.size() - 1);
        packets_sent++;
    endtask

    task automatic build_header(logic [7:0] b0, logic [7:0] idlen);
        tx_bytes.delete();
        tx_bytes.push_back(b0);
        repeat (4) tx_bytes.push_back(8'($urandom));
        tx_bytes.push_back(idlen);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_bytes.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [63:0] data);
        logic [63:0] mask;
        mask = (idx == REG_ID_LEN) ? 64'h1F :
               (idx == REG_ID_HIGH) ? 64'hFFFF_FFFF : '1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_ID_LEN:  cfg_len = data[4:0];
            REG_ID_LOW:  cfg_lo  = data;
            REG_ID_MID:  cfg_mid = data;
            REG_ID_HIGH: cfg_hi  = data[31:0];
            default: ;
        endcase
        // read back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) != (data & mask))
            report_mismatch("register readback", data & mask, prdata & mask);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_id_config(logic [4:0] len, logic [63:0] lo, logic [63:0] mid,
                                 logic [31:0] hi);
        wait_for_results();
        apb_write(REG_ID_LEN, ({$urandom, $urandom} & ~64'h1F) | 64'(len));
        apb_write(REG_ID_LOW, lo);
        apb_write(REG_ID_MID, mid);
        apb_write(REG_ID_HIGH, {$urandom, hi});
    endtask

    // mostly well-formed headers with random content, the rest broken
    task automatic random_packet();
        int kind, idl, n, m;
        logic [15:0] plen;
        kind = $urandom_range(0, 9);
        idl = (cfg_len >= 1 && cfg_len <= MAX_ID_LEN) ? int'(cfg_len) :
              $urandom_range(1, MAX_ID_LEN);
        n = MIN_PKT_LEN + idl + $urandom_range(0, 6);
        build_header(8'($urandom) | 8'h80, 8'(idl));
        while (tx_bytes.size() < n) tx_bytes.push_back(8'($urandom));
        plen = 16'(n);
        case (kind)
            4: plen = 16'($urandom_range(n, 65535));
            5: begin
                // claimed length longer than the stream, which ends at the ID length byte or inside the ID
                plen = 16'($urandom_range(n, 65535));
                m = $urandom_range(MIN_PKT_LEN, MIN_PKT_LEN + idl);
                while (tx_bytes.size() > m) void'(tx_bytes.pop_back());
            end
            6: tx_bytes[0] = tx_bytes[0] & 8'h7F;
            7: begin
                case ($urandom_range(0, 2))
                    0: tx_bytes[IDLEN_POS] = 8'h00;
                    1: tx_bytes[IDLEN_POS] = 8'($urandom_range(MAX_ID_LEN + 1, 255));
                    default: tx_bytes[IDLEN_POS] = 8'((idl % MAX_ID_LEN) + 1);
                endcase
            end
            8: plen = 16'($urandom_range(0, MIN_PKT_LEN + idl - 1));
            9: begin
                tx_bytes.delete();
                repeat ($urandom_range(1, 8)) tx_bytes.push_back(8'($urandom));
                plen = 16'($urandom);
            end
            default: ;
        endcase
        send_packet(plen);
    endtask

    task automatic test_directed_status();
        set_id_config(5'd2, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
        // claimed length below the fixed header
        send_byte(8'hFF, 16'd5, 1'b1);
        // long-header bit clear
        send_byte(8'h7F, 16'hFFFF, 1'b1);
        // stream ends before the ID length byte
        send_byte(8'h80, 16'd6, 1'b1);
        // ID length zero
        build_header(8'hC0, 8'd0);
        send_packet(16'd0 + 16'd26);
        // ID length differs from the register
        build_header(8'hFF, 8'd3);
        send_packet(16'd26);
        // claimed length cannot hold the ID
        build_header(8'h80, 8'd2);
        send_packet(16'd7);
        // checks pass, stream stops inside the ID field
        build_header(8'hC3, 8'd2);
        tx_bytes.push_back(8'h00);
        send_packet(16'hFFFF);
    endtask

    task automatic test_random_traffic();
        int budget, sent;
        for (int ph = 0; ph < 8; ph++) begin
            budget = 70;
            case (ph)
                0: set_id_config(5'd1, '0, '0, '0);
                1: set_id_config(5'd20, '1, '1, '1);
                2: begin
                    set_id_config(5'd0, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
                    budget = 30;
                end
                3: begin
                    set_id_config(5'd31, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
                    budget = 30;
                end
                4: begin
                    set_id_config(5'd21, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
                    budget = 30;
                end
                default: set_id_config(5'($urandom_range(1, MAX_ID_LEN)), {$urandom, $urandom},
                                       {$urandom, $urandom}, $urandom);
            endcase
            sent = 0;
            while (sent < budget) begin
                random_packet();
                sent += tx_bytes.size();
                // hold the sender until the output side has caught up
                if (ph == 5 && sent > budget / 2 && sent - tx_bytes.size() <= budget / 2)
                    wait_for_results();
            end
        end
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        set_id_config(5'd4, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
        repeat (3) random_packet();
        // packet state must be back at its start after each packet
        build_header(8'h80, 8'd4);
        repeat (4) tx_bytes.push_back(8'($urandom));
        send_packet(16'd10);
    endtask

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected result", 64'(0), 64'(o_out_byte));
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_byte !== want.out_byte)
                    report_mismatch("out_byte", 64'(want.out_byte), 64'(o_out_byte));
                if (o_out_last !== want.out_last)
                    report_mismatch("out_last", 64'(want.out_last), 64'(o_out_last));
                if (o_status !== want.status)
                    report_mismatch("status", 64'(want.status), 64'(o_status));
            end
            if (o_out_last === 1'b1)
                status_seen[o_status]++;
            bytes_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_status();
        test_random_traffic();
        test_back_to_back();
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (expected_bytes.size() != 0)
            report_mismatch("results missing", 64'(expected_bytes.size()), 64'(0));
        $display("covered %0d packets, %0d bytes checked, %0d ID bytes rewritten",
                 packets_sent, bytes_checked, bytes_rewritten);
        $display("status ok/args/header/idlen/mismatch/short: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
